// ----- design/assert_macros.svh -----
// Assertion macros shared by the hotplug governor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BCHG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define BCHG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bchg_pkg.sv -----
// Types and constants of the big core hotplug governor.
`default_nettype none

package bchg_pkg;

  // Widths fixed by the request and result formats
  localparam int CORE_IDX_W = 2;
  localparam int MAX_NCORES = 4;
  localparam int MASK_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LOAD_W     = 7;
  localparam int NUM_W      = 71;
  localparam int DIV_STEPS  = 7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_SINGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CORES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_THRESHOLD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_UP     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_DOWN   = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_DELAY_MS       = 16'd100;
  localparam logic        RST_SCREEN_SINGLE  = 1'b1;
  localparam logic [2:0]  RST_MAX_CORES      = 3'd4;
  localparam logic [2:0]  RST_MIN_CORES      = 3'd2;
  localparam logic [6:0]  RST_UP_THRESHOLD   = 7'd80;
  localparam logic [6:0]  RST_DOWN_THRESHOLD = 7'd25;
  localparam logic [7:0]  RST_CYCLES_UP      = 8'd1;
  localparam logic [7:0]  RST_CYCLES_DOWN    = 8'd1;

  // Request codes
  localparam logic [1:0] REQ_TICK       = 2'd0;
  localparam logic [1:0] REQ_SCREEN_ON  = 2'd1;
  localparam logic [1:0] REQ_SCREEN_OFF = 2'd2;

  // Action codes
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_PLUG    = 2'd1;
  localparam logic [1:0] ACT_UNPLUG  = 2'd2;

  // Fixed delays and load scale
  localparam logic [15:0]       FORCE_DELAY_MS  = 16'd2000;
  localparam logic [15:0]       RESUME_DELAY_MS = 16'd3000;
  localparam logic [LOAD_W-1:0] LOAD_FULL       = 7'd100;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] wall_core0;
    logic [63:0] idle_core0;
    logic [63:0] wall_core1;
    logic [63:0] idle_core1;
    logic [63:0] wall_core2;
    logic [63:0] idle_core2;
    logic [63:0] wall_core3;
    logic [63:0] idle_core3;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] online_mask;
    logic [1:0]        action;
    logic [1:0]        action_core;
    logic [15:0]       next_delay_ms;
    logic [LOAD_W-1:0] fastest_load;
    logic [LOAD_W-1:0] slowest_load;
    logic [2:0]        online_count;
    logic              forced_all;
  } out_item_t;

  typedef struct packed {
    logic [15:0] delay_ms;
    logic        screen_off_single;
    logic [2:0]  max_cores;
    logic [2:0]  min_cores;
    logic [6:0]  up_threshold;
    logic [6:0]  down_threshold;
    logic [7:0]  cycles_before_up;
    logic [7:0]  cycles_before_down;
  } cfg_t;

  // What a captured request turns into
  typedef enum logic [1:0] {
    KIND_EVAL,
    KIND_ON,
    KIND_OFF,
    KIND_IGNORE
  } req_kind_e;

  // Controller to datapath
  typedef struct packed {
    logic                  accept;
    logic                  eval_start;
    logic                  diff;
    logic                  prep;
    logic                  scale;
    logic                  div_step;
    logic                  fold;
    logic                  decide;
    logic                  other;
    logic [2:0]            shift;
    logic [CORE_IDX_W-1:0] core;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_kind_e         kind;
    logic [MASK_W-1:0] online;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/bchg_cfg.sv -----
// Configuration registers of the hotplug governor.
`default_nettype none

module bchg_cfg
  import bchg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  // Write the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ms           <= RST_DELAY_MS;
      cfg_q.screen_off_single  <= RST_SCREEN_SINGLE;
      cfg_q.max_cores          <= RST_MAX_CORES;
      cfg_q.min_cores          <= RST_MIN_CORES;
      cfg_q.up_threshold       <= RST_UP_THRESHOLD;
      cfg_q.down_threshold     <= RST_DOWN_THRESHOLD;
      cfg_q.cycles_before_up   <= RST_CYCLES_UP;
      cfg_q.cycles_before_down <= RST_CYCLES_DOWN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY_MS:       cfg_q.delay_ms           <= cfg_data_i[15:0];
        CFG_SCREEN_SINGLE:  cfg_q.screen_off_single  <= cfg_data_i[0];
        CFG_MAX_CORES:      cfg_q.max_cores          <= cfg_data_i[2:0];
        CFG_MIN_CORES:      cfg_q.min_cores          <= cfg_data_i[2:0];
        CFG_UP_THRESHOLD:   cfg_q.up_threshold       <= cfg_data_i[6:0];
        CFG_DOWN_THRESHOLD: cfg_q.down_threshold     <= cfg_data_i[6:0];
        CFG_CYCLES_UP:      cfg_q.cycles_before_up   <= cfg_data_i[7:0];
        CFG_CYCLES_DOWN:    cfg_q.cycles_before_down <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/bchg_dp.sv -----
// Datapath of the hotplug governor: samples, load divider, decision, result.
`default_nettype none
`include "assert_macros.svh"

module bchg_dp
  import bchg_pkg::*;
#(
  parameter int NCORES = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t in_item_i,
  input  wire cfg_t     cfg_i,
  input  wire dp_cmd_t  cmd_i,
  output dp_status_t    status_o,
  output out_item_t     out_item_o
);

  localparam int CW = $clog2(NCORES);
  localparam logic [NCORES-1:0] ALL_MASK = '1;

  function automatic logic [63:0] wall_sel(in_item_t it, logic [CORE_IDX_W-1:0] c);
    case (c)
      2'd0:    return it.wall_core0;
      2'd1:    return it.wall_core1;
      2'd2:    return it.wall_core2;
      default: return it.wall_core3;
    endcase
  endfunction

  function automatic logic [63:0] idle_sel(in_item_t it, logic [CORE_IDX_W-1:0] c);
    case (c)
      2'd0:    return it.idle_core0;
      2'd1:    return it.idle_core1;
      2'd2:    return it.idle_core2;
      default: return it.idle_core3;
    endcase
  endfunction

  function automatic logic [2:0] popcount(logic [NCORES-1:0] m);
    logic [2:0] n;
    n = '0;
    for (int c = 0; c < NCORES; c++) begin
      n = n + 3'(m[c]);
    end
    return n;
  endfunction

  // Persistent state
  logic [63:0]       prev_wall_q [NCORES];
  logic [63:0]       prev_idle_q [NCORES];
  logic [NCORES-1:0] online_q;
  logic [7:0]        tick_q;
  logic              ticking_q;

  // Per-request working registers
  in_item_t          item_q;
  logic [63:0]       dw_q, di_q, b_q;
  logic              zero_q;
  logic [NUM_W-1:0]  rem_q;
  logic [LOAD_W-1:0] quot_q;
  logic [LOAD_W-1:0] c0_q, fast_q, slow_q;
  logic [CORE_IDX_W-1:0] slow_core_q;
  logic [2:0]        count_q;
  out_item_t         out_q;

  logic [63:0]       cur_wall, cur_idle;
  logic [NUM_W-1:0]  b_ext, num, trial;
  logic [LOAD_W-1:0] fold_load;
  logic [15:0]       eff_delay;
  req_kind_e         kind;

  // Select the current core's counters
  assign cur_wall  = wall_sel(item_q, cmd_i.core);
  assign cur_idle  = idle_sel(item_q, cmd_i.core);
  assign b_ext     = NUM_W'(b_q);
  assign num       = (b_ext << 6) + (b_ext << 5) + (b_ext << 2);
  assign trial     = NUM_W'(dw_q) << cmd_i.shift;
  assign fold_load = zero_q ? '0 : quot_q;
  assign eff_delay = (cfg_i.delay_ms == '0) ? 16'd1 : cfg_i.delay_ms;

  // Classify the captured request
  always_comb begin
    if (item_q.req_type == REQ_TICK && ticking_q) begin
      kind = KIND_EVAL;
    end else if (item_q.req_type == REQ_SCREEN_ON && cfg_i.screen_off_single) begin
      kind = KIND_ON;
    end else if (item_q.req_type == REQ_SCREEN_OFF && cfg_i.screen_off_single) begin
      kind = KIND_OFF;
    end else begin
      kind = KIND_IGNORE;
    end
  end

  assign status_o.kind   = kind;
  assign status_o.online = MASK_W'(online_q);

  // Decision after all online cores are sampled
  logic [LOAD_W-1:0]     slow_f;
  logic [2:0]            count_f;
  logic                  off_found, plug_ok, unplug_ok, forced;
  logic [CORE_IDX_W-1:0] off_idx;
  logic [NCORES-1:0]     mask_dec, mask_oth;
  logic [7:0]            tick_dec;
  logic                  store_all;
  out_item_t             out_d;

  always_comb begin
    slow_f  = (c0_q < slow_q) ? c0_q : slow_q;
    count_f = count_q + 3'd1;
    off_found = 1'b0;
    off_idx   = '0;
    for (int c = NCORES - 1; c >= 1; c--) begin
      if (!online_q[c]) begin
        off_found = 1'b1;
        off_idx   = CORE_IDX_W'(c);
      end
    end
    plug_ok = (slow_f > cfg_i.up_threshold) && (count_f < cfg_i.max_cores) &&
              (tick_q >= cfg_i.cycles_before_up) && off_found;
    unplug_ok = !(slow_f > cfg_i.up_threshold) && (slow_core_q != '0) &&
                (fast_q < cfg_i.down_threshold) && (count_f > cfg_i.min_cores) &&
                (tick_q >= cfg_i.cycles_before_down);
    forced = count_f < cfg_i.min_cores;
    mask_dec = online_q;
    if (plug_ok) begin
      mask_dec = mask_dec | (NCORES'(1) << off_idx);
    end
    if (unplug_ok) begin
      mask_dec = mask_dec & ~(NCORES'(1) << slow_core_q);
    end
    tick_dec = (plug_ok || unplug_ok) ? 8'd0 : tick_q;

    case (kind)
      KIND_ON:  mask_oth = ALL_MASK;
      KIND_OFF: mask_oth = NCORES'(1);
      default:  mask_oth = online_q;
    endcase

    store_all = (cmd_i.decide && forced) || (cmd_i.other && kind == KIND_ON);

    // Assemble the result
    if (cmd_i.decide) begin
      out_d.online_mask   = MASK_W'(forced ? ALL_MASK : mask_dec);
      out_d.action        = plug_ok ? ACT_PLUG : (unplug_ok ? ACT_UNPLUG : ACT_NONE);
      out_d.action_core   = plug_ok ? off_idx : (unplug_ok ? slow_core_q : '0);
      out_d.next_delay_ms = forced ? FORCE_DELAY_MS : eff_delay;
      out_d.fastest_load  = fast_q;
      out_d.slowest_load  = slow_f;
      out_d.online_count  = count_f;
      out_d.forced_all    = forced;
    end else begin
      out_d.online_mask   = MASK_W'(mask_oth);
      out_d.action        = ACT_NONE;
      out_d.action_core   = '0;
      case (kind)
        KIND_ON:  out_d.next_delay_ms = RESUME_DELAY_MS;
        KIND_OFF: out_d.next_delay_ms = '0;
        default:  out_d.next_delay_ms = ticking_q ? eff_delay : '0;
      endcase
      out_d.fastest_load  = '0;
      out_d.slowest_load  = '0;
      out_d.online_count  = popcount(online_q);
      out_d.forced_all    = 1'b0;
    end
  end

  // Working registers and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_item_i;
    end
    if (cmd_i.diff) begin
      dw_q <= cur_wall - prev_wall_q[cmd_i.core[CW-1:0]];
      di_q <= cur_idle - prev_idle_q[cmd_i.core[CW-1:0]];
    end
    if (cmd_i.prep) begin
      zero_q <= (dw_q == '0) || (dw_q < di_q);
      b_q    <= dw_q - di_q;
    end
    if (cmd_i.scale) begin
      rem_q  <= num;
      quot_q <= '0;
    end
    if (cmd_i.div_step && rem_q >= trial) begin
      rem_q  <= rem_q - trial;
      quot_q <= quot_q | (LOAD_W'(1) << cmd_i.shift);
    end
    if (cmd_i.fold) begin
      if (cmd_i.core == '0) begin
        c0_q        <= fold_load;
        fast_q      <= fold_load;
        slow_q      <= LOAD_FULL;
        slow_core_q <= '0;
        count_q     <= '0;
      end else begin
        count_q <= count_q + 3'd1;
        if (fold_load < slow_q) begin
          slow_core_q <= cmd_i.core;
          slow_q      <= fold_load;
        end else if (fold_load > fast_q) begin
          fast_q <= fold_load;
        end
      end
    end
    if (cmd_i.decide || cmd_i.other) begin
      out_q <= out_d;
    end
  end

  // Persistent governor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCORES; c++) begin
        prev_wall_q[c] <= '0;
        prev_idle_q[c] <= '0;
      end
      online_q  <= ALL_MASK;
      tick_q    <= '0;
      ticking_q <= 1'b1;
    end else begin
      for (int c = 0; c < NCORES; c++) begin
        if (store_all || (cmd_i.diff && cmd_i.core == CORE_IDX_W'(c))) begin
          prev_wall_q[c] <= wall_sel(item_q, CORE_IDX_W'(c));
          prev_idle_q[c] <= idle_sel(item_q, CORE_IDX_W'(c));
        end
      end
      if (cmd_i.eval_start) begin
        online_q[0] <= 1'b1;
        if (tick_q != 8'hff) begin
          tick_q <= tick_q + 8'd1;
        end
      end
      if (cmd_i.decide) begin
        online_q <= forced ? ALL_MASK : mask_dec;
        tick_q   <= tick_dec;
      end
      if (cmd_i.other) begin
        online_q <= mask_oth;
        if (kind == KIND_ON) begin
          ticking_q <= 1'b1;
        end else if (kind == KIND_OFF) begin
          ticking_q <= 1'b0;
        end
      end
    end
  end

  assign out_item_o = out_q;

  `BCHG_ASSERT(a_load_range, cmd_i.fold |-> (fold_load <= LOAD_FULL), "load above full scale")
  `BCHG_ASSERT_NEXT(a_core0_online, cmd_i.eval_start, online_q[0], "core 0 not online")
  `BCHG_ASSERT(a_decide_eval, cmd_i.decide |-> (kind == KIND_EVAL), "decision outside a tick")

endmodule

`default_nettype wire

// ----- design/bchg_ctrl.sv -----
// Controller of the hotplug governor: sequences sampling, division and decision.
`default_nettype none
`include "assert_macros.svh"

module bchg_ctrl
  import bchg_pkg::*;
#(
  parameter int NCORES = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_DIFF   = 4'd2;
  localparam logic [3:0] S_PREP   = 4'd3;
  localparam logic [3:0] S_SCALE  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_FOLD   = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_OTHER  = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [CORE_IDX_W-1:0] core_q, core_d;
  logic [2:0]            k_q, k_d;
  logic                  out_valid_q, out_valid_d;
  logic                  slot_free;
  logic                  nxt_found;
  logic [CORE_IDX_W-1:0] nxt_core;
  logic [7:0]            step_cmds;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Find the next online core above the current one
  always_comb begin
    nxt_found = 1'b0;
    nxt_core  = '0;
    for (int c = NCORES - 1; c >= 1; c--) begin
      if (status_i.online[c] && CORE_IDX_W'(c) > core_q) begin
        nxt_found = 1'b1;
        nxt_core  = CORE_IDX_W'(c);
      end
    end
  end

  // Sequence one request
  always_comb begin
    state_d = state_q;
    core_d  = core_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.core  = core_q;
    cmd_o.shift = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        if (status_i.kind == KIND_EVAL) begin
          cmd_o.eval_start = 1'b1;
          core_d  = '0;
          state_d = S_DIFF;
        end else begin
          state_d = S_OTHER;
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        k_d     = 3'(DIV_STEPS - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (k_q == '0) begin
          state_d = S_FOLD;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        if (nxt_found) begin
          core_d  = nxt_core;
          state_d = S_DIFF;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (slot_free) begin
          cmd_o.decide = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_OTHER: begin
        if (slot_free) begin
          cmd_o.other = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.decide || cmd_o.other) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      core_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      core_q      <= core_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // Step commands that must never overlap
  assign step_cmds = {cmd_o.eval_start, cmd_o.diff, cmd_o.prep, cmd_o.scale,
                      cmd_o.div_step, cmd_o.fold, cmd_o.decide, cmd_o.other};

  `BCHG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "no stall after request")
  `BCHG_ASSERT(a_load_slot, (cmd_o.decide || cmd_o.other) |-> slot_free, "result overwritten")
  `BCHG_ASSERT(a_cmd_onehot, $onehot0(step_cmds), "overlapping commands")

endmodule

`default_nettype wire

// ----- design/big_core_hotplug_governor.sv -----
// Top level of the big core hotplug governor.
// Requests carry a type (tick, screen on, screen off) and the cumulative
// wall and idle counters of four big cores; each request gives one result.
// A request is taken when in_valid_i is high and in_stall_o is low; a result
// is taken when out_valid_o is high and out_stall_i is low.
// A tick samples core 0 and every other online core in turn. For each core it
// runs a counter difference, zero check, scaling by 100 and a 7-step
// restoring divide on a 71-bit remainder, then folds into the min/max loads.
// A tick then ends in a decision step; screen events and ignored requests
// go from the start state straight to their result step.
// The next request can be taken in the cycle after the result register is loaded,
// so one result may wait in the output register while the next request runs.
// When out_stall_i holds a result and another one is ready, the controller
// waits before its decision step (or its screen event step) and in_stall_o stays high.
// Reset brings all cores online, clears the stored counters and tick count,
// starts ticking and loads the register defaults. Configuration writes are
// taken at any edge where cfg_we_i is high and apply to later requests.
`default_nettype none

module big_core_hotplug_governor
  import bchg_pkg::*;
#(
  parameter int BIG_CORES = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NCORES = (BIG_CORES < MAX_NCORES) ? BIG_CORES : MAX_NCORES;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  bchg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bchg_ctrl #(
    .NCORES (NCORES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bchg_dp #(
    .NCORES (NCORES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ----- tb/big_core_hotplug_governor_test.sv -----
// Self-checking testbench for the big core hotplug governor.
module big_core_hotplug_governor_test
  import bchg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Request code outside the defined set
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_REQS = 155;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              req;
    bit                    typed;
    out_item_t             want;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Governor state as the checker sees it
  cfg_t        regs_q;
  logic [63:0] seen_wall [4];
  logic [63:0] seen_idle [4];
  logic [3:0]  online_q;
  int          ticks_since_change;
  bit          ticking_on;
  bit          req_dropped;

  // Running counters the request generator advances
  logic [63:0] run_wall [4];
  logic [63:0] run_idle [4];

  out_item_t pending_results [$];
  dir_row_t  dir_rows [$];
  int        mismatches = 0;
  int        gap_pct;
  int        stall_pct;

  big_core_hotplug_governor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Busy percent over one interval, exact floor
  function automatic int busy_pct(logic [63:0] dw, logic [63:0] di);
    logic [127:0] scaled;
    if (dw == '0 || dw < di) return 0;
    scaled = 128'(dw - di) * 128'd100;
    return int'(scaled / 128'(dw));
  endfunction

  // Apply one request to the state copy and return the result it gives
  function automatic out_item_t govern_step(in_item_t r);
    out_item_t   o;
    logic [63:0] w [4];
    logic [63:0] d [4];
    logic [15:0] dly;
    int          c, ld, c0, fast, slow, slow_core, n;
    w[0] = r.wall_core0; d[0] = r.idle_core0;
    w[1] = r.wall_core1; d[1] = r.idle_core1;
    w[2] = r.wall_core2; d[2] = r.idle_core2;
    w[3] = r.wall_core3; d[3] = r.idle_core3;
    dly = (regs_q.delay_ms == '0) ? 16'd1 : regs_q.delay_ms;
    o = '0;
    o.online_count = 3'($countones(online_q));
    o.next_delay_ms = ticking_on ? dly : 16'd0;
    req_dropped = 1'b0;
    if (r.req_type == REQ_TICK && ticking_on) begin
      online_q[0] = 1'b1;
      if (ticks_since_change < 255) ticks_since_change++;
      c0 = busy_pct(w[0] - seen_wall[0], d[0] - seen_idle[0]);
      seen_wall[0] = w[0];
      seen_idle[0] = d[0];
      fast = c0;
      slow = 100;
      slow_core = 0;
      n = 0;
      // Sample the other online cores, min wins over max
      for (c = 1; c < 4; c++) begin
        if (online_q[c]) begin
          ld = busy_pct(w[c] - seen_wall[c], d[c] - seen_idle[c]);
          seen_wall[c] = w[c];
          seen_idle[c] = d[c];
          n++;
          if (ld < slow) begin
            slow_core = c;
            slow = ld;
          end else if (ld > fast) begin
            fast = ld;
          end
        end
      end
      if (c0 < slow) slow = c0;
      n++;
      // Plug the lowest offline core or drop the slowest one
      if (slow > int'(regs_q.up_threshold)) begin
        if (n < int'(regs_q.max_cores) &&
            ticks_since_change >= int'(regs_q.cycles_before_up)) begin
          for (c = 1; c < 4 && o.action == ACT_NONE; c++) begin
            if (!online_q[c]) begin
              online_q[c] = 1'b1;
              o.action = ACT_PLUG;
              o.action_core = 2'(c);
              ticks_since_change = 0;
            end
          end
        end
      end else if (slow_core > 0 && fast < int'(regs_q.down_threshold)) begin
        if (n > int'(regs_q.min_cores) &&
            ticks_since_change >= int'(regs_q.cycles_before_down)) begin
          online_q[slow_core] = 1'b0;
          o.action = ACT_UNPLUG;
          o.action_core = 2'(slow_core);
          ticks_since_change = 0;
        end
      end
      o.next_delay_ms = dly;
      // Too few cores: bring everything back
      if (n < int'(regs_q.min_cores)) begin
        online_q = 4'hF;
        for (c = 0; c < 4; c++) begin
          seen_wall[c] = w[c];
          seen_idle[c] = d[c];
        end
        o.next_delay_ms = FORCE_DELAY_MS;
        o.forced_all = 1'b1;
      end
      o.fastest_load = 7'(fast);
      o.slowest_load = 7'(slow);
      o.online_count = 3'(n);
    end else if (r.req_type == REQ_SCREEN_ON && regs_q.screen_off_single) begin
      online_q = 4'hF;
      for (c = 0; c < 4; c++) begin
        seen_wall[c] = w[c];
        seen_idle[c] = d[c];
      end
      ticking_on = 1'b1;
      o.next_delay_ms = RESUME_DELAY_MS;
    end else if (r.req_type == REQ_SCREEN_OFF && regs_q.screen_off_single) begin
      online_q = 4'b0001;
      ticking_on = 1'b0;
      o.next_delay_ms = 16'd0;
    end else begin
      req_dropped = 1'b1;
    end
    o.online_mask = online_q;
    return o;
  endfunction

  // Advance the running counters by a load pattern and wrap them in a request
  function automatic in_item_t make_req(logic [1:0] kind);
    in_item_t    r;
    logic [63:0] dw, di;
    int          c, pct, mode;
    mode = $urandom_range(0, 3);
    for (c = 0; c < 4; c++) begin
      case ($urandom_range(0, 29))
        0:       dw = '0;
        1, 2:    dw = {$urandom, $urandom};
        default: dw = 64'($urandom_range(1, 200000));
      endcase
      case (mode)
        0:       pct = $urandom_range(85, 100);
        1:       pct = $urandom_range(0, 20);
        2:       pct = $urandom_range(0, 100);
        default: pct = $urandom_range(0, 1) ? $urandom_range(85, 100) : $urandom_range(0, 20);
      endcase
      di = (dw / 100) * (100 - pct) + ((dw % 100) * (100 - pct)) / 100;
      run_wall[c] += dw;
      run_idle[c] += di;
    end
    r.req_type = kind;
    r.wall_core0 = run_wall[0]; r.idle_core0 = run_idle[0];
    r.wall_core1 = run_wall[1]; r.idle_core1 = run_idle[1];
    r.wall_core2 = run_wall[2]; r.idle_core2 = run_idle[2];
    r.wall_core3 = run_wall[3]; r.idle_core3 = run_idle[3];
    return r;
  endfunction

  // Fully random request; the counters restart from it
  function automatic in_item_t noise_req();
    in_item_t r;
    r.req_type = 2'($urandom_range(0, 3));
    r.wall_core0 = {$urandom, $urandom}; r.idle_core0 = {$urandom, $urandom};
    r.wall_core1 = {$urandom, $urandom}; r.idle_core1 = {$urandom, $urandom};
    r.wall_core2 = {$urandom, $urandom}; r.idle_core2 = {$urandom, $urandom};
    r.wall_core3 = {$urandom, $urandom}; r.idle_core3 = {$urandom, $urandom};
    run_wall[0] = r.wall_core0; run_idle[0] = r.idle_core0;
    run_wall[1] = r.wall_core1; run_idle[1] = r.idle_core1;
    run_wall[2] = r.wall_core2; run_idle[2] = r.idle_core2;
    run_wall[3] = r.wall_core3; run_idle[3] = r.idle_core3;
    return r;
  endfunction

  function automatic in_item_t flat_req(logic [1:0] kind, logic [63:0] w, logic [63:0] i);
    return in_item_t'{kind, w, i, w, i, w, i, w, i};
  endfunction

  function automatic dir_row_t req_row(in_item_t r);
    dir_row_t row;
    row = '{default: '0};
    row.req = r;
    return row;
  endfunction

  function automatic dir_row_t chk_row(in_item_t r, out_item_t want);
    dir_row_t row;
    row = req_row(r);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Offer one request, hold it until taken, then queue its result
  task automatic push_req(in_item_t r, bit typed, out_item_t want);
    out_item_t got;
    in_item_i <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = govern_step(r);
    pending_results.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every queued result, then let the pipe go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_DELAY_MS:       regs_q.delay_ms = val;
      CFG_SCREEN_SINGLE:  regs_q.screen_off_single = val[0];
      CFG_MAX_CORES:      regs_q.max_cores = val[2:0];
      CFG_MIN_CORES:      regs_q.min_cores = val[2:0];
      CFG_UP_THRESHOLD:   regs_q.up_threshold = val[6:0];
      CFG_DOWN_THRESHOLD: regs_q.down_threshold = val[6:0];
      CFG_CYCLES_UP:      regs_q.cycles_before_up = val[7:0];
      CFG_CYCLES_DOWN:    regs_q.cycles_before_down = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_regs(cfg_t c);
    put_reg(CFG_DELAY_MS, c.delay_ms);
    put_reg(CFG_SCREEN_SINGLE, 16'(c.screen_off_single));
    put_reg(CFG_MAX_CORES, 16'(c.max_cores));
    put_reg(CFG_MIN_CORES, 16'(c.min_cores));
    put_reg(CFG_UP_THRESHOLD, 16'(c.up_threshold));
    put_reg(CFG_DOWN_THRESHOLD, 16'(c.down_threshold));
    put_reg(CFG_CYCLES_UP, 16'(c.cycles_before_up));
    put_reg(CFG_CYCLES_DOWN, 16'(c.cycles_before_down));
    cfg_we_i <= 1'b0;
  endtask

  // Result side: stall in random bursts
  initial begin : result_stall
    int hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 99) < stall_pct) hold = $urandom_range(1, 13);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with none expected: %h", $time, out_item_o);
      end else begin
        want = pending_results.pop_front();
        if (out_item_o !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch (expected/actual) mask %h/%h action %0d/%0d core %0d/%0d",
                     $time, want.online_mask, out_item_o.online_mask,
                     want.action, out_item_o.action, want.action_core, out_item_o.action_core);
            $display("  delay %0d/%0d fast %0d/%0d slow %0d/%0d count %0d/%0d forced %0d/%0d",
                     want.next_delay_ms, out_item_o.next_delay_ms,
                     want.fastest_load, out_item_o.fastest_load,
                     want.slowest_load, out_item_o.slowest_load,
                     want.online_count, out_item_o.online_count,
                     want.forced_all, out_item_o.forced_all);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    cfg_t     ph;
    in_item_t r;
    int       p, c, sel, useful;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    gap_pct = 0;
    stall_pct = 0;
    regs_q = '{RST_DELAY_MS, RST_SCREEN_SINGLE, RST_MAX_CORES, RST_MIN_CORES,
               RST_UP_THRESHOLD, RST_DOWN_THRESHOLD, RST_CYCLES_UP, RST_CYCLES_DOWN};
    online_q = 4'hF;
    ticks_since_change = 0;
    ticking_on = 1'b1;
    req_dropped = 1'b0;
    for (c = 0; c < 4; c++) begin
      seen_wall[c] = '0;
      seen_idle[c] = '0;
      run_wall[c] = '0;
      run_idle[c] = '0;
    end

    // Directed: idle cores unplug, busy cores plug, counter extremes, screen events
    dir_rows.push_back(chk_row(flat_req(REQ_TICK, '0, '0),
      out_item_t'{4'b1101, ACT_UNPLUG, 2'd1, 16'd100, 7'd0, 7'd0, 3'd4, 1'b0}));
    dir_rows.push_back(chk_row(
      in_item_t'{REQ_TICK, 64'd1000, 64'd0, 64'd0, 64'd0, 64'd1000, 64'd0, 64'd1000, 64'd0},
      out_item_t'{4'hF, ACT_PLUG, 2'd1, 16'd100, 7'd100, 7'd100, 3'd3, 1'b0}));
    dir_rows.push_back(chk_row(flat_req(REQ_TICK, '1, '0),
      out_item_t'{4'hF, ACT_NONE, 2'd0, 16'd100, 7'd100, 7'd100, 3'd4, 1'b0}));
    dir_rows.push_back(chk_row(flat_req(REQ_SCREEN_OFF, '0, '0),
      out_item_t'{4'b0001, ACT_NONE, 2'd0, 16'd0, 7'd0, 7'd0, 3'd4, 1'b0}));
    dir_rows.push_back(chk_row(flat_req(REQ_TICK, '1, '1),
      out_item_t'{4'b0001, ACT_NONE, 2'd0, 16'd0, 7'd0, 7'd0, 3'd1, 1'b0}));
    dir_rows.push_back(chk_row(flat_req(REQ_UNUSED, '0, '1),
      out_item_t'{4'b0001, ACT_NONE, 2'd0, 16'd0, 7'd0, 7'd0, 3'd1, 1'b0}));
    dir_rows.push_back(chk_row(
      flat_req(REQ_SCREEN_ON, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000),
      out_item_t'{4'hF, ACT_NONE, 2'd0, 16'd3000, 7'd0, 7'd0, 3'd1, 1'b0}));
    dir_rows.push_back(chk_row(flat_req(REQ_UNUSED, '1, '1),
      out_item_t'{4'hF, ACT_NONE, 2'd0, 16'd100, 7'd0, 7'd0, 3'd4, 1'b0}));
    // Zero delay reads back as one
    dir_rows.push_back(reg_row(CFG_DELAY_MS, 16'd0));
    dir_rows.push_back(chk_row(flat_req(REQ_UNUSED, '0, '0),
      out_item_t'{4'hF, ACT_NONE, 2'd0, 16'd1, 7'd0, 7'd0, 3'd4, 1'b0}));
    // Wrapped counters, idle above wall, uneven loads
    dir_rows.push_back(req_row(flat_req(REQ_TICK, 64'h10, '1)));
    dir_rows.push_back(req_row(in_item_t'{REQ_TICK, 64'h13, 64'h0, '1,
      64'h5555_5555_5555_5555, 64'h10, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0}));
    dir_rows.push_back(req_row(in_item_t'{REQ_TICK, 64'hAAAA_AAAA_AAAA_AAB0,
      64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFF0, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5565, 64'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h5555_5555_5555_5555}));
    // Limits and thresholds out of range
    dir_rows.push_back(reg_row(CFG_MAX_CORES, 16'd7));
    dir_rows.push_back(req_row(make_req(REQ_TICK)));
    dir_rows.push_back(reg_row(CFG_MIN_CORES, 16'd7));
    dir_rows.push_back(req_row(make_req(REQ_TICK)));
    // Screen handling disabled
    dir_rows.push_back(reg_row(CFG_SCREEN_SINGLE, 16'd0));
    dir_rows.push_back(req_row(make_req(REQ_SCREEN_OFF)));
    dir_rows.push_back(req_row(make_req(REQ_SCREEN_ON)));
    dir_rows.push_back(reg_row(CFG_UP_THRESHOLD, 16'd127));
    dir_rows.push_back(reg_row(CFG_DOWN_THRESHOLD, 16'd127));
    dir_rows.push_back(req_row(make_req(REQ_TICK)));
    dir_rows.push_back(reg_row(CFG_CYCLES_UP, 16'd255));
    dir_rows.push_back(reg_row(CFG_CYCLES_DOWN, 16'd0));
    dir_rows.push_back(req_row(make_req(REQ_TICK)));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_write) begin
        settle();
        put_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
        cfg_we_i <= 1'b0;
      end else begin
        push_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // Random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      settle();
      // Restart ticking before the setting can turn screen handling off
      if (!ticking_on) begin
        push_req(make_req(REQ_SCREEN_ON), 1'b0, '0);
        settle();
      end
      case (p)
        0: ph = '{RST_DELAY_MS, RST_SCREEN_SINGLE, RST_MAX_CORES, RST_MIN_CORES,
                  RST_UP_THRESHOLD, RST_DOWN_THRESHOLD, RST_CYCLES_UP, RST_CYCLES_DOWN};
        1: ph = '{16'd1, 1'b1, 3'd1, 3'd1, 7'd0, 7'd0, 8'd0, 8'd0};
        2: ph = '{16'hFFFF, 1'b1, 3'd7, 3'd4, 7'd127, 7'd100, 8'd255, 8'd255};
        default: begin
          ph.delay_ms = 16'($urandom_range(0, 65535));
          ph.screen_off_single = (p == 3) ? 1'b0 : 1'($urandom_range(0, 1));
          ph.max_cores = 3'($urandom_range(0, 4) == 0 ? $urandom_range(0, 7)
                                                      : $urandom_range(1, 4));
          ph.min_cores = 3'($urandom_range(0, 4) == 0 ? $urandom_range(0, 7)
                                                      : $urandom_range(1, 3));
          ph.up_threshold = 7'($urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                                         : $urandom_range(40, 100));
          ph.down_threshold = 7'($urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                                           : $urandom_range(0, 60));
          ph.cycles_before_up = 8'($urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 4));
          ph.cycles_before_down = 8'($urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 4));
        end
      endcase
      program_regs(ph);
      // No idling at all in the closing phase
      case ((p == PHASES - 1) ? 0 : $urandom_range(0, 3))
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 12; stall_pct = 35; end
        2:       begin gap_pct = 35; stall_pct = 12; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      useful = 0;
      while (useful < PHASE_REQS) begin
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 13)) @(negedge clk_i);
        end
        // Now and then hold off until the pipe has emptied
        if ($urandom_range(0, 249) == 0) settle();
        sel = $urandom_range(0, 99);
        if (!ticking_on && regs_q.screen_off_single && sel < 60) r = make_req(REQ_SCREEN_ON);
        else if (sel < 80) r = make_req(REQ_TICK);
        else if (sel < 86) r = make_req(REQ_SCREEN_ON);
        else if (sel < 91) r = make_req(REQ_SCREEN_OFF);
        else if (sel < 93) r = make_req(REQ_UNUSED);
        else r = noise_req();
        push_req(r, 1'b0, '0);
        if (!req_dropped) useful++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/bchg_pkg.sv
design/bchg_cfg.sv
design/bchg_dp.sv
design/bchg_ctrl.sv
design/big_core_hotplug_governor.sv
tb/big_core_hotplug_governor_test.sv
